// File: hw/rtl/dts_pkg.sv
// ----------------------------------------------------------------------------
// dts_pkg: shared types and constants of the deadline task scheduler
// Table geometry, operation and status codes, table entry layout and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dts_pkg;

   localparam int TASKS  = 16;
   localparam int IDX_W  = $clog2(TASKS);
   localparam int CNT_W  = $clog2(TASKS + 1);
   localparam int MODE_W = 2;
   localparam int ID_W   = 8;
   localparam int TIME_W = 16;
   localparam int STAT_W = 2;
   localparam int RANK_W = TIME_W + 2;

   // operation codes carried by the mode field
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

   // response status codes
   localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NONE      = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] deadline;
      logic [TIME_W-1:0] remaining;
   } dts_entry_type;

   typedef struct packed {
      logic              capture;
      logic              ins_write;
      logic              rd_en;
      logic              rd_next;
      logic              tick_eval;
      logic              idx_inc;
      logic              shift_write;
      logic              count_dec;
      logic              tick_write;
      logic              put;
      logic              put_run;
      logic [STAT_W-1:0] put_status;
   } dts_cmd_type;

   typedef struct packed {
      logic full;
      logic scan_end;
      logic shift_end;
      logic id_match;
      logic best_found;
      logic rsp_free;
   } dts_stat_type;

endpackage

`default_nettype wire

// File: hw/rtl/dts_req_if.sv
// ----------------------------------------------------------------------------
// dts_req_if: request channel of the deadline task scheduler
// Valid/ready channel carrying one operation with its task fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface dts_req_if;
   logic                         valid;
   logic                         ready;
   logic [dts_pkg::MODE_W-1:0]   mode;
   logic [dts_pkg::ID_W-1:0]     task_id;
   logic [dts_pkg::TIME_W-1:0]   arrival_time;
   logic [dts_pkg::TIME_W-1:0]   deadline_time;
   logic [dts_pkg::TIME_W-1:0]   exec_time;
   logic [dts_pkg::TIME_W-1:0]   now_time;

   modport source (
      output valid, mode, task_id, arrival_time, deadline_time, exec_time, now_time,
      input  ready
   );
   modport sink (
      input  valid, mode, task_id, arrival_time, deadline_time, exec_time, now_time,
      output ready
   );
endinterface

`default_nettype wire

// File: hw/rtl/dts_rsp_if.sv
// ----------------------------------------------------------------------------
// dts_rsp_if: response channel of the deadline task scheduler
// Valid/ready channel carrying the status of one finished operation.
// ----------------------------------------------------------------------------
`default_nettype none

interface dts_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [dts_pkg::STAT_W-1:0]   status;
   logic [dts_pkg::ID_W-1:0]     chosen_id;
   logic                         finished;

   modport source (output valid, status, chosen_id, finished, input ready);
   modport sink   (input  valid, status, chosen_id, finished, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/deadline_task_scheduler.sv
// sequence: insert passes ST_INS, an ignored mode goes straight to ST_PUT; delete scans in
// ST_DEL_RD/ST_DEL_CHK and shifts in ST_SHF_RD/ST_SHF_WR; tick scans in ST_TCK_RD/ST_TCK_CHK,
// then ST_TCK_WR if one is eligible; the scan reads entries via the registered read port
// throughput: one transaction at a time, next request taken the cycle after the response is
// loaded into the output register; a new response waits while the previous one is unread
// reset: synchronous, clears entry count, policy and control; table contents stay undefined
// ----------------------------------------------------------------------------
// deadline_task_scheduler: earliest deadline / least slack task scheduler
// Task table in insertion order with insert, delete by id and scheduling
// tick operations; policy register selects the ranking rule.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_task_scheduler (
   input  wire       clock,
   input  wire       reset,
   dts_req_if.sink   req_bus,
   dts_rsp_if.source rsp_bus,
   input  wire       csr_write_en,
   input  wire       csr_write_data
);
   import dts_pkg::*;

   // command and status groups between sequencer and datapath
   dts_cmd_type  cmd;
   dts_stat_type stat;

   // sequencer: decodes the mode of each request transaction and steps
   // through the table scan, the delete shift and the tick update
   dts_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_mode  (req_bus.mode),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: task memory, count, scan index, best candidate, policy
   // register and the response output register
   dts_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus)
   );

endmodule

`default_nettype wire

// File: hw/rtl/dts_datapath.sv
// ----------------------------------------------------------------------------
// dts_datapath: task table, scan registers and response register
// Holds the table memory, entry count, scan index, best candidate and the
// policy register; acts on commands from the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module dts_datapath (
   input  wire                        clock,
   input  wire                        reset,
   input  wire dts_pkg::dts_cmd_type  cmd,
   output dts_pkg::dts_stat_type      stat,
   input  wire                        csr_write_en,
   input  wire                        csr_write_data,
   dts_req_if.sink                    req_bus,
   dts_rsp_if.source                  rsp_bus
);
   import dts_pkg::*;

   dts_entry_type mem [TASKS];
   dts_entry_type rd_data_ff;

   logic [ID_W-1:0]   id_ff;
   logic [TIME_W-1:0] arrival_ff;
   logic [TIME_W-1:0] deadline_ff;
   logic [TIME_W-1:0] exec_ff;
   logic [TIME_W-1:0] now_ff;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              policy_ff;

   logic                     best_found_ff;
   logic [IDX_W-1:0]         best_idx_ff;
   logic signed [RANK_W-1:0] best_rank_ff;
   dts_entry_type            best_ff;

   logic                     rsp_valid_ff;
   logic [STAT_W-1:0]        rsp_status_ff;
   logic [ID_W-1:0]          rsp_id_ff;
   logic                     rsp_fin_ff;

   logic [CNT_W-1:0]         idx_next;
   logic [CNT_W-1:0]         rd_addr;
   logic                     we;
   logic [IDX_W-1:0]         waddr;
   dts_entry_type            wdata;
   logic                     eligible;
   logic signed [RANK_W-1:0] rank;
   logic                     better;

   assign idx_next = idx_ff + CNT_W'(1);
   assign rd_addr  = cmd.rd_next ? idx_next : idx_ff;

   // candidate ranking of the entry just read
   always_comb begin
      eligible = (rd_data_ff.arrival <= now_ff) && (rd_data_ff.remaining != '0);
      if (policy_ff) begin
         rank = $signed({2'b00, rd_data_ff.deadline}) - $signed({2'b00, now_ff})
              - $signed({2'b00, rd_data_ff.remaining});
      end else begin
         rank = $signed({2'b00, rd_data_ff.deadline});
      end
      better = eligible && (!best_found_ff || (rank < best_rank_ff));
   end

   // single write port of the table
   always_comb begin
      we    = 1'b0;
      waddr = idx_ff[IDX_W-1:0];
      wdata = rd_data_ff;
      if (cmd.ins_write) begin
         we    = 1'b1;
         waddr = count_ff[IDX_W-1:0];
         wdata = '{id: id_ff, arrival: arrival_ff, deadline: deadline_ff,
                   remaining: exec_ff};
      end else if (cmd.shift_write) begin
         we = 1'b1;
      end else if (cmd.tick_write) begin
         we              = 1'b1;
         waddr           = best_idx_ff;
         wdata           = best_ff;
         wdata.remaining = best_ff.remaining - TIME_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr[IDX_W-1:0]];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.ins_write) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
      idx_in = idx_ff;
      if (cmd.capture) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         idx_ff        <= '0;
         policy_ff     <= 1'b0;
         best_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
         if (csr_write_en) begin
            policy_ff <= csr_write_data;
         end
         if (cmd.capture) begin
            best_found_ff <= 1'b0;
         end else if (cmd.tick_eval && better) begin
            best_found_ff <= 1'b1;
         end
         if (cmd.put) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         id_ff       <= req_bus.task_id;
         arrival_ff  <= req_bus.arrival_time;
         deadline_ff <= req_bus.deadline_time;
         exec_ff     <= req_bus.exec_time;
         now_ff      <= req_bus.now_time;
      end
      if (cmd.tick_eval && better) begin
         best_idx_ff  <= idx_ff[IDX_W-1:0];
         best_rank_ff <= rank;
         best_ff      <= rd_data_ff;
      end
      if (cmd.put) begin
         rsp_status_ff <= cmd.put_status;
         rsp_id_ff     <= cmd.put_run ? best_ff.id : '0;
         rsp_fin_ff    <= cmd.put_run && (best_ff.remaining == TIME_W'(1));
      end
   end

   assign stat.full       = (count_ff == CNT_W'(TASKS));
   assign stat.scan_end   = (idx_ff >= count_ff);
   assign stat.shift_end  = (idx_next >= count_ff);
   assign stat.id_match   = (rd_data_ff.id == id_ff);
   assign stat.best_found = best_found_ff;
   assign stat.rsp_free   = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.status    = rsp_status_ff;
   assign rsp_bus.chosen_id = rsp_id_ff;
   assign rsp_bus.finished  = rsp_fin_ff;

endmodule

`default_nettype wire

// File: hw/rtl/dts_controller.sv
// ----------------------------------------------------------------------------
// dts_controller: operation sequencer of the deadline task scheduler
// One-hot state machine that walks insert, delete and tick through the
// datapath one table entry at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module dts_controller (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   input  wire [dts_pkg::MODE_W-1:0]    req_mode,
   output logic                         req_ready,
   input  wire dts_pkg::dts_stat_type   stat,
   output dts_pkg::dts_cmd_type         cmd
);
   import dts_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b00_0000_0001,
      ST_INS     = 10'b00_0000_0010,
      ST_DEL_RD  = 10'b00_0000_0100,
      ST_DEL_CHK = 10'b00_0000_1000,
      ST_SHF_RD  = 10'b00_0001_0000,
      ST_SHF_WR  = 10'b00_0010_0000,
      ST_TCK_RD  = 10'b00_0100_0000,
      ST_TCK_CHK = 10'b00_1000_0000,
      ST_TCK_WR  = 10'b01_0000_0000,
      ST_PUT     = 10'b10_0000_0000
   } dts_state_type;

   dts_state_type     state_ff, state_in;
   logic [STAT_W-1:0] code_ff, code_in;
   logic              run_ff, run_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      run_in   = run_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               run_in      = 1'b0;
               case (req_mode)
                  MODE_INSERT: state_in = ST_INS;
                  MODE_DELETE: state_in = ST_DEL_RD;
                  MODE_TICK:   state_in = ST_TCK_RD;
                  default: begin
                     code_in  = STAT_DONE;
                     state_in = ST_PUT;
                  end
               endcase
            end
         end
         ST_INS: begin
            if (stat.full) begin
               code_in = STAT_FULL;
            end else begin
               cmd.ins_write = 1'b1;
               code_in       = STAT_DONE;
            end
            state_in = ST_PUT;
         end
         ST_DEL_RD: begin
            if (stat.scan_end) begin
               code_in  = STAT_NOT_FOUND;
               state_in = ST_PUT;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ST_DEL_CHK;
            end
         end
         ST_DEL_CHK: begin
            if (stat.id_match) begin
               state_in = ST_SHF_RD;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_DEL_RD;
            end
         end
         ST_SHF_RD: begin
            if (stat.shift_end) begin
               cmd.count_dec = 1'b1;
               code_in       = STAT_DONE;
               state_in      = ST_PUT;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_next = 1'b1;
               state_in    = ST_SHF_WR;
            end
         end
         ST_SHF_WR: begin
            cmd.shift_write = 1'b1;
            cmd.idx_inc     = 1'b1;
            state_in        = ST_SHF_RD;
         end
         ST_TCK_RD: begin
            if (stat.scan_end) begin
               if (stat.best_found) begin
                  state_in = ST_TCK_WR;
               end else begin
                  code_in  = STAT_NONE;
                  state_in = ST_PUT;
               end
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ST_TCK_CHK;
            end
         end
         ST_TCK_CHK: begin
            cmd.tick_eval = 1'b1;
            cmd.idx_inc   = 1'b1;
            state_in      = ST_TCK_RD;
         end
         ST_TCK_WR: begin
            cmd.tick_write = 1'b1;
            code_in        = STAT_DONE;
            run_in         = 1'b1;
            state_in       = ST_PUT;
         end
         ST_PUT: begin
            if (stat.rsp_free) begin
               cmd.put        = 1'b1;
               cmd.put_status = code_ff;
               cmd.put_run    = run_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         code_ff  <= STAT_DONE;
         run_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
         run_ff   <= run_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/dts_checker.sv
// ----------------------------------------------------------------------------
// dts_checker: port-level assertions of the deadline task scheduler
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dts_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_ready,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input wire [dts_pkg::STAT_W-1:0]    rsp_status,
   input wire [dts_pkg::ID_W-1:0]      rsp_chosen_id,
   input wire                          rsp_finished
);
   import dts_pkg::*;

   // nothing left in the output register after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // one transaction at a time: busy right after an accepted request
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request ready right after accept");

   // only a tick that ran a task reports an id or completion
   a_run_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STAT_DONE)) |-> (rsp_chosen_id == '0 && !rsp_finished))
      else $error("run fields set on a failed operation");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_chosen_id)
          && $stable(rsp_finished)))
      else $error("stalled response changed");

endmodule

bind deadline_task_scheduler dts_checker u_dts_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_status    (rsp_bus.status),
   .rsp_chosen_id (rsp_bus.chosen_id),
   .rsp_finished  (rsp_bus.finished)
);

`default_nettype wire
